/* design/acw_pkg.sv */
// Package for the AIFF chunk walker: shared types, header codes, chunk tags
// and small helper functions. No dependencies.
`default_nettype none

package acw_pkg;

  // Byte offsets run on 33 bits and saturate
  localparam int unsigned PosWidth = 33;
  localparam logic [PosWidth-1:0] PosMax = '1;

  // Width of the size fields carried on the result channel
  localparam int unsigned OutSizeWidth = 32;

  // Byte classification codes
  typedef enum logic [2:0] {
    ClsFormHdr  = 3'd0,
    ClsChunkHdr = 3'd1,
    ClsPayload  = 3'd2,
    ClsPad      = 3'd3,
    ClsBeyond   = 3'd4
  } byte_class_e;

  // Chunk kind codes
  typedef enum logic [2:0] {
    KindOther = 3'd0,
    KindName  = 3'd1,
    KindAuth  = 3'd2,
    KindCopy  = 3'd3,
    KindAnno  = 3'd4,
    KindComt  = 3'd5,
    KindId3   = 3'd6
  } chunk_kind_e;

  // Four-character chunk IDs, big-endian
  localparam logic [31:0] TagName = 32'h4E41_4D45;  // "NAME"
  localparam logic [31:0] TagAuth = 32'h4155_5448;  // "AUTH"
  localparam logic [31:0] TagCopy = 32'h2863_2920;  // "(c) "
  localparam logic [31:0] TagAnno = 32'h414E_4E4F;  // "ANNO"
  localparam logic [31:0] TagComt = 32'h434F_4D54;  // "COMT"
  localparam logic [31:0] TagId3  = 32'h4944_3320;  // "ID3 "

  // Input transaction payload
  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_item_t;

  // Map a chunk ID to its kind
  function automatic chunk_kind_e kind_of(input logic [31:0] tag);
    chunk_kind_e k;
    case (tag)
      TagName: k = KindName;
      TagAuth: k = KindAuth;
      TagCopy: k = KindCopy;
      TagAnno: k = KindAnno;
      TagComt: k = KindComt;
      TagId3:  k = KindId3;
      default: k = KindOther;
    endcase
    return k;
  endfunction

  // Saturating offset increment
  function automatic logic [PosWidth-1:0] sat_inc(input logic [PosWidth-1:0] v);
    logic [PosWidth-1:0] r;
    r = (v == PosMax) ? v : v + PosWidth'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/acw_in_if.sv */
// Input channel of the AIFF chunk walker: one file byte per transaction.
// Depends on nothing.
`default_nettype none

interface acw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, data_byte, file_start, input ready);
  modport sink   (input valid, data_byte, file_start, output ready);
endinterface

`default_nettype wire

/* design/acw_out_if.sv */
// Result channel of the AIFF chunk walker: one classification per byte.
// Depends on nothing.
`default_nettype none

interface acw_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_class;
  logic [2:0]  chunk_kind;
  logic        header_done;
  logic [31:0] chunk_size;
  logic [31:0] form_size;
  logic [32:0] byte_offset;
  logic        id3_valid;
  logic [32:0] id3_offset;

  modport source (output valid, byte_class, chunk_kind, header_done, chunk_size,
                  form_size, byte_offset, id3_valid, id3_offset, input ready);
  modport sink   (input valid, byte_class, chunk_kind, header_done, chunk_size,
                  form_size, byte_offset, id3_valid, id3_offset, output ready);
endinterface

`default_nettype wire

/* design/acw_in_stage.sv */
// Input register stage of the AIFF chunk walker.
// Depends on acw_pkg and acw_in_if.
`default_nettype none

module acw_in_stage (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  acw_in_if.sink            in_i,
  output acw_pkg::in_item_t item_o,
  output logic              item_valid_o,
  input  wire logic         item_ready_i
);

  logic              valid_q;
  acw_pkg::in_item_t item_q;
  logic              load;

  // Stage takes a new byte when empty or when its content moves on
  assign load      = !valid_q || item_ready_i;
  assign in_i.ready = load;

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_i.valid;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load && in_i.valid) begin
      item_q.data_byte  <= in_i.data_byte;
      item_q.file_start <= in_i.file_start;
    end
  end

  assign item_o       = item_q;
  assign item_valid_o = valid_q;

endmodule

`default_nettype wire

/* design/acw_walker.sv */
// Parse state machine and result register of the AIFF chunk walker.
// Depends on acw_pkg and acw_out_if.
`default_nettype none

module acw_walker #(
  parameter int unsigned SIZE_WIDTH = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire acw_pkg::in_item_t item_i,
  input  wire logic              item_valid_i,
  output logic                   item_ready_o,
  acw_out_if.source              out_o
);

  localparam int unsigned PW = acw_pkg::PosWidth;
  localparam int unsigned OW = acw_pkg::OutSizeWidth;
  localparam logic [31:0] SizeMask = 32'((64'(1) << SIZE_WIDTH) - 64'(1));

  // Header byte counts
  localparam logic [3:0] SizeFirst   = 4'd4;
  localparam logic [3:0] SizeLast    = 4'd7;
  localparam logic [3:0] FormHdrLast = 4'd11;
  localparam logic [PW-1:0] FormBias = PW'(8);

  typedef enum logic [2:0] {
    PhForm,
    PhHdr,
    PhPay,
    PhPad,
    PhBeyond
  } phase_e;

  // Parse state
  logic [PW-1:0]         pos_q, pos_c, pos_d;
  phase_e                ph_q, ph_c, ph_w, ph_d;
  logic [3:0]            hc_q, hc_c, hc_d;
  logic [31:0]           tag_q, tag_c, tag_d;
  logic [31:0]           size_q, size_c, size_d;
  logic [SIZE_WIDTH-1:0] rem_q, rem_c, rem_d;
  acw_pkg::chunk_kind_e  kind_q, kind_c, kind_d;
  logic [SIZE_WIDTH-1:0] form_q, form_c, form_d;
  logic [PW-1:0]         id3pos_q, id3pos_c, id3pos_d;
  logic                  id3seen_q, id3seen_c, id3seen_d;

  // Result register
  logic                  out_valid_q;
  acw_pkg::byte_class_e  cls_q, cls_d;
  acw_pkg::chunk_kind_e  rkind_q, rkind_d;
  logic                  done_q, done_d;
  logic [OW-1:0]         csize_q, csize_d;
  logic [PW-1:0]         offs_q;

  // Header scratch
  logic [31:0]           hdr_tag, hdr_size, masked;
  logic [PW-1:0]         form_end;
  logic                  advance;

  assign item_ready_o = !out_valid_q || out_o.ready;
  assign advance      = item_valid_i && item_ready_o;

  // Next state and result for the byte in the input register
  always_comb begin
    // File start restarts from the reset state
    if (item_i.file_start) begin
      pos_c     = '0;
      ph_c      = PhForm;
      hc_c      = '0;
      tag_c     = '0;
      size_c    = '0;
      rem_c     = '0;
      kind_c    = acw_pkg::KindOther;
      form_c    = '0;
      id3pos_c  = '0;
      id3seen_c = 1'b0;
    end else begin
      pos_c     = pos_q;
      ph_c      = ph_q;
      hc_c      = hc_q;
      tag_c     = tag_q;
      size_c    = size_q;
      rem_c     = rem_q;
      kind_c    = kind_q;
      form_c    = form_q;
      id3pos_c  = id3pos_q;
      id3seen_c = id3seen_q;
    end

    hc_d      = hc_c;
    tag_d     = tag_c;
    size_d    = size_c;
    rem_d     = rem_c;
    kind_d    = kind_c;
    form_d    = form_c;
    id3pos_d  = id3pos_c;
    id3seen_d = id3seen_c;
    cls_d     = acw_pkg::ClsBeyond;
    rkind_d   = acw_pkg::KindOther;
    done_d    = 1'b0;
    csize_d   = '0;
    hdr_tag   = '0;
    hdr_size  = '0;
    masked    = '0;

    // Form end is checked only where a new chunk header would start
    form_end = PW'(form_c) + FormBias;
    if (ph_c == PhHdr && hc_c == '0 && pos_c >= form_end) begin
      ph_w = PhBeyond;
    end else begin
      ph_w = ph_c;
    end
    ph_d = ph_w;

    unique case (ph_w)
      PhForm: begin
        cls_d = acw_pkg::ClsFormHdr;
        if (hc_c >= SizeFirst && hc_c <= SizeLast) begin
          size_d = {size_c[23:0], item_i.data_byte};
        end
        if (hc_c == SizeLast) begin
          form_d = size_d[SIZE_WIDTH-1:0];
        end
        if (hc_c >= FormHdrLast) begin
          ph_d = PhHdr;
          hc_d = '0;
        end else begin
          hc_d = hc_c + 4'd1;
        end
      end
      PhHdr: begin
        cls_d = acw_pkg::ClsChunkHdr;
        // First header byte clears the ID and size shifters
        hdr_tag  = (hc_c == '0) ? '0 : tag_c;
        hdr_size = (hc_c == '0) ? '0 : size_c;
        if (hc_c < SizeFirst) begin
          tag_d  = {hdr_tag[23:0], item_i.data_byte};
          size_d = hdr_size;
        end else begin
          tag_d  = hdr_tag;
          size_d = {hdr_size[23:0], item_i.data_byte};
        end
        if (hc_c >= SizeLast) begin
          masked  = size_d & SizeMask;
          size_d  = masked;
          done_d  = 1'b1;
          kind_d  = acw_pkg::kind_of(tag_d);
          rkind_d = kind_d;
          csize_d = masked;
          rem_d   = masked[SIZE_WIDTH-1:0];
          if (kind_d == acw_pkg::KindId3) begin
            id3pos_d  = acw_pkg::sat_inc(pos_c);
            id3seen_d = 1'b1;
          end
          ph_d = (rem_d != '0) ? PhPay : PhHdr;
          hc_d = '0;
        end else begin
          hc_d = hc_c + 4'd1;
        end
      end
      PhPay: begin
        cls_d   = acw_pkg::ClsPayload;
        rkind_d = kind_c;
        csize_d = size_c;
        if (rem_c != '0) begin
          rem_d = rem_c - SIZE_WIDTH'(1);
        end
        // Odd sizes get one pad byte
        if (rem_d == '0) begin
          ph_d = size_c[0] ? PhPad : PhHdr;
        end
      end
      PhPad: begin
        cls_d   = acw_pkg::ClsPad;
        rkind_d = kind_c;
        csize_d = size_c;
        ph_d    = PhHdr;
      end
      default: begin
        cls_d = acw_pkg::ClsBeyond;
        ph_d  = PhBeyond;
      end
    endcase

    pos_d = acw_pkg::sat_inc(pos_c);
  end

  // State and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      ph_q        <= PhForm;
      hc_q        <= '0;
      tag_q       <= '0;
      size_q      <= '0;
      rem_q       <= '0;
      kind_q      <= acw_pkg::KindOther;
      form_q      <= '0;
      id3pos_q    <= '0;
      id3seen_q   <= 1'b0;
      out_valid_q <= 1'b0;
      cls_q       <= acw_pkg::ClsFormHdr;
      rkind_q     <= acw_pkg::KindOther;
      done_q      <= 1'b0;
      csize_q     <= '0;
      offs_q      <= '0;
    end else begin
      if (item_ready_o) begin
        out_valid_q <= item_valid_i;
      end
      if (advance) begin
        pos_q     <= pos_d;
        ph_q      <= ph_d;
        hc_q      <= hc_d;
        tag_q     <= tag_d;
        size_q    <= size_d;
        rem_q     <= rem_d;
        kind_q    <= kind_d;
        form_q    <= form_d;
        id3pos_q  <= id3pos_d;
        id3seen_q <= id3seen_d;
        cls_q     <= cls_d;
        rkind_q   <= rkind_d;
        done_q    <= done_d;
        csize_q   <= csize_d;
        offs_q    <= pos_c;
      end
    end
  end

  // Result channel; form size and ID3 fields are the post-update state
  assign out_o.valid       = out_valid_q;
  assign out_o.byte_class  = cls_q;
  assign out_o.chunk_kind  = rkind_q;
  assign out_o.header_done = done_q;
  assign out_o.chunk_size  = csize_q;
  assign out_o.form_size   = OW'(form_q);
  assign out_o.byte_offset = offs_q;
  assign out_o.id3_valid   = id3seen_q;
  assign out_o.id3_offset  = id3pos_q;

endmodule

`default_nettype wire

/* design/aiff_chunk_walker_unit.sv */
// Top level of the AIFF chunk walker: input register stage and walker.
// Depends on acw_pkg, acw_in_if, acw_out_if, acw_in_stage, acw_walker.
//
//   channel | dir | payload                                       | handshake
//   in_i    | in  | data_byte, file_start                         | valid/ready
//   out_o   | out | byte_class, chunk_kind, header_done,          | valid/ready
//           |     | chunk_size, form_size, byte_offset,           |
//           |     | id3_valid, id3_offset                         |
//
// One byte per cycle sustained while the result channel is ready; each input
// transaction passes through the input register, then the result register.
// Parse state advances when the byte moves into the result register.
// Reset clears the parse state and both valid flags; file_start restarts
// parsing in-band. A stalled result holds; the input stalls only once both
// stages are full.
`default_nettype none

module aiff_chunk_walker_unit #(
  parameter int unsigned SIZE_WIDTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  acw_in_if.sink    in_i,
  acw_out_if.source out_o
);

  acw_pkg::in_item_t item;
  logic              item_valid;
  logic              item_ready;

  acw_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready)
  );

  acw_walker #(
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

/* tb/sv/aiff_chunk_walker_unit_tb.sv */
`timescale 1ns / 100ps
// Testbench for aiff_chunk_walker_unit. It streams AIFF-like files one byte per
// transaction, classifies each byte in a local walker and checks every result.
// Depends on acw_pkg, acw_in_if, acw_out_if and the unit itself.

module aiff_chunk_walker_unit_tb;
  import acw_pkg::*;

  localparam int unsigned SizeWidth = 32;
  localparam logic [31:0] SizeMask = 32'((64'd1 << SizeWidth) - 64'd1);
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned ByteTarget = 1850;
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned HoldCycles = 80;
  localparam logic [31:0] FormId = 32'h464F_524D;    // "FORM"
  localparam logic [31:0] FormAiff = 32'h4149_4646;  // "AIFF"

  typedef enum logic [2:0] {
    WalkForm,
    WalkHdr,
    WalkPay,
    WalkPad,
    WalkBeyond
  } walk_phase_e;

  typedef struct packed {
    byte_class_e cls;
    chunk_kind_e kind;
    logic        hdr_done;
    logic [31:0] chunk_size;
    logic [31:0] form_size;
    logic [32:0] offset;
    logic        id3_valid;
    logic [32:0] id3_offset;
  } byte_report_t;

  logic clk;
  logic rst_n;

  acw_in_if  in_if ();
  acw_out_if out_if ();

  aiff_chunk_walker_unit #(
    .SIZE_WIDTH(SizeWidth)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // File bytes waiting to be sent, and classifications waiting to come back
  in_item_t     file_bytes_q[$];
  byte_report_t class_reports_q[$];

  int unsigned send_gap_pct;
  int unsigned recv_gap_pct;
  int unsigned stall_left;
  int unsigned cycle_count;
  bit          in_taken;
  bit          failed;

  // Local walker state
  logic [32:0] walk_pos;
  logic [32:0] walk_form_end;
  walk_phase_e walk_phase;
  int unsigned walk_hdr_cnt;
  logic [31:0] walk_tag;
  logic [31:0] walk_size;
  logic [32:0] walk_left;
  chunk_kind_e walk_kind;
  logic [32:0] walk_id3_pos;
  logic        walk_id3_seen;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void restart_walk();
    walk_pos      = '0;
    walk_form_end = '0;
    walk_phase    = WalkForm;
    walk_hdr_cnt  = 0;
    walk_tag      = '0;
    walk_size     = '0;
    walk_left     = '0;
    walk_kind     = KindOther;
    walk_id3_pos  = '0;
    walk_id3_seen = 1'b0;
  endfunction

  // Classify one accepted byte and queue the result it must produce
  function automatic void classify_byte(input logic [7:0] b, input logic start);
    byte_report_t r;
    logic [32:0]  here;
    if (start) restart_walk();
    here = walk_pos;
    r = '0;
    r.cls = ClsBeyond;
    r.kind = KindOther;

    // Form end is only looked at where a new chunk header would begin
    if (walk_phase == WalkHdr && walk_hdr_cnt == 0 && here >= walk_form_end) begin
      walk_phase = WalkBeyond;
    end

    case (walk_phase)
      WalkForm: begin
        r.cls = ClsFormHdr;
        if (walk_hdr_cnt >= 4 && walk_hdr_cnt < 8) walk_size = {walk_size[23:0], b};
        if (walk_hdr_cnt == 7) walk_form_end = {1'b0, walk_size & SizeMask} + 33'd8;
        walk_hdr_cnt++;
        if (walk_hdr_cnt == 12) begin
          walk_phase = WalkHdr;
          walk_hdr_cnt = 0;
        end
      end
      WalkHdr: begin
        r.cls = ClsChunkHdr;
        if (walk_hdr_cnt == 0) begin
          walk_tag = '0;
          walk_size = '0;
        end
        if (walk_hdr_cnt < 4) walk_tag = {walk_tag[23:0], b};
        else walk_size = {walk_size[23:0], b};
        if (walk_hdr_cnt == 7) begin
          walk_size &= SizeMask;
          case (walk_tag)
            TagName: walk_kind = KindName;
            TagAuth: walk_kind = KindAuth;
            TagCopy: walk_kind = KindCopy;
            TagAnno: walk_kind = KindAnno;
            TagComt: walk_kind = KindComt;
            TagId3:  walk_kind = KindId3;
            default: walk_kind = KindOther;
          endcase
          r.hdr_done = 1'b1;
          r.kind = walk_kind;
          r.chunk_size = walk_size;
          walk_left = {1'b0, walk_size};
          // ID3 payload starts on the next byte; the last ID3 chunk wins
          if (walk_kind == KindId3) begin
            walk_id3_pos = (here == PosMax) ? here : here + 33'd1;
            walk_id3_seen = 1'b1;
          end
          walk_phase = (walk_size != 0) ? WalkPay : WalkHdr;
          walk_hdr_cnt = 0;
        end else begin
          walk_hdr_cnt++;
        end
      end
      WalkPay: begin
        r.cls = ClsPayload;
        r.kind = walk_kind;
        r.chunk_size = walk_size;
        if (walk_left != 0) walk_left--;
        if (walk_left == 0) walk_phase = walk_size[0] ? WalkPad : WalkHdr;
      end
      WalkPad: begin
        r.cls = ClsPad;
        r.kind = walk_kind;
        r.chunk_size = walk_size;
        walk_phase = WalkHdr;
      end
      default: walk_phase = WalkBeyond;
    endcase

    r.form_size = (walk_form_end >= 33'd8) ? 32'(walk_form_end - 33'd8) : '0;
    r.offset = here;
    r.id3_valid = walk_id3_seen;
    r.id3_offset = walk_id3_pos;
    walk_pos = (here == PosMax) ? here : here + 33'd1;
    class_reports_q.insert(class_reports_q.size(), r);
  endfunction

  function automatic void compare_field(input string name, input logic [32:0] want,
                                        input logic [32:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failed = 1'b1;
    end
  endfunction

  // Stimulus builders
  function automatic void push_byte(input logic [7:0] b, input logic start);
    in_item_t it;
    it.data_byte = b;
    it.file_start = start;
    file_bytes_q.insert(file_bytes_q.size(), it);
  endfunction

  // Big-endian word; start only applies to its first byte
  function automatic void push_word(input logic [31:0] w, input logic start);
    push_byte(w[31:24], start);
    push_byte(w[23:16], 1'b0);
    push_byte(w[15:8], 1'b0);
    push_byte(w[7:0], 1'b0);
  endfunction

  // Chunk header plus body bytes; pad only when the body is complete and odd
  function automatic void push_chunk(input logic [31:0] tag, input logic [31:0] size,
                                     input int unsigned body);
    push_word(tag, 1'b0);
    push_word(size, 1'b0);
    repeat (body) push_byte(8'($urandom_range(255)), 1'b0);
    if (size[0] && body == size) push_byte(8'($urandom_range(255)), 1'b0);
  endfunction

  function automatic logic [31:0] pick_tag();
    logic [31:0] t;
    case ($urandom_range(7))
      0: t = TagName;
      1: t = TagAuth;
      2: t = TagCopy;
      3: t = TagAnno;
      4: t = TagComt;
      5: t = TagId3;
      6: t = $urandom();
      default: t = TagId3 ^ (32'd1 << $urandom_range(31));  // near miss
    endcase
    return t;
  endfunction

  // Queue one file (mostly well formed) and return how many bytes it added
  function automatic int unsigned push_random_file();
    int unsigned n0;
    int unsigned nchunks;
    int unsigned total;
    logic [31:0] tags[4];
    logic [31:0] sizes[4];
    logic [31:0] form_len;
    n0 = file_bytes_q.size();

    // Noise: random bytes with an occasional restart
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 30)) push_byte(8'($urandom_range(255)), $urandom_range(19) == 0);
      return file_bytes_q.size() - n0;
    end

    nchunks = $urandom_range(4);
    total = 4;
    for (int i = 0; i < nchunks; i++) begin
      tags[i] = pick_tag();
      sizes[i] = ($urandom_range(5) == 0) ? 32'd0 : 32'($urandom_range(1, 14));
      total += 8 + sizes[i] + sizes[i][0];
    end
    case ($urandom_range(7))
      0: form_len = total - $urandom_range(total);  // form ends early
      1: form_len = total + $urandom_range(1, 9);   // file shorter than declared
      default: form_len = total;
    endcase

    push_word(FormId, 1'b1);
    push_word(form_len, 1'b0);
    push_word(($urandom_range(3) == 0) ? 32'($urandom()) : FormAiff, 1'b0);
    for (int i = 0; i < nchunks; i++) push_chunk(tags[i], sizes[i], sizes[i]);

    // Huge chunk that the next restart cuts short
    if ($urandom_range(5) == 0) begin
      push_chunk(pick_tag(), $urandom_range(1) ? 32'hFFFF_FFFF : 32'($urandom()),
                 $urandom_range(6));
    end
    // Trailing bytes past the declared form
    repeat ($urandom_range(4)) push_byte(8'($urandom_range(255)), 1'b0);
    return file_bytes_q.size() - n0;
  endfunction

  // Sender: next transaction at the falling edge once the current one is taken
  always @(negedge clk) begin
    if (rst_n && (in_if.valid !== 1'b1 || in_taken)) begin
      if (file_bytes_q.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
        in_if.valid      <= 1'b1;
        in_if.data_byte  <= file_bytes_q[0].data_byte;
        in_if.file_start <= file_bytes_q[0].file_start;
        void'(file_bytes_q.pop_front());
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, or a long hold when one is requested
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Monitor: predict on each input transaction, check each result transaction
  always @(posedge clk) begin : monitor
    byte_report_t want;
    cycle_count++;
    in_taken = rst_n && (in_if.valid === 1'b1) && (in_if.ready === 1'b1);
    if (in_taken) classify_byte(in_if.data_byte, in_if.file_start);
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (class_reports_q.size() == 0) begin
        $error("unexpected result at byte_offset 0x%0h", out_if.byte_offset);
        failed = 1'b1;
      end else begin
        want = class_reports_q.pop_front();
        compare_field("byte_class", want.cls, out_if.byte_class);
        compare_field("chunk_kind", want.kind, out_if.chunk_kind);
        compare_field("header_done", want.hdr_done, out_if.header_done);
        compare_field("chunk_size", want.chunk_size, out_if.chunk_size);
        compare_field("form_size", want.form_size, out_if.form_size);
        compare_field("byte_offset", want.offset, out_if.byte_offset);
        compare_field("id3_valid", want.id3_valid, out_if.id3_valid);
        compare_field("id3_offset", want.id3_offset, out_if.id3_offset);
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("Simulation FAILED");
    $finish;
  end

  // Sender pause: every queued byte sent and every result back
  task automatic wait_drained();
    wait (file_bytes_q.size() == 0 && in_if.valid === 1'b0);
    wait (class_reports_q.size() == 0);
    @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned queued;
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.data_byte  = '0;
    in_if.file_start = 1'b0;
    out_if.ready     = 1'b0;
    send_gap_pct     = 0;
    recv_gap_pct     = 0;
    stall_left       = 0;
    cycle_count      = 0;
    in_taken         = 1'b0;
    failed           = 1'b0;
    restart_walk();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Straight out of reset, no restart: form size zero ends the form inside
    // its own header, so the bytes after it are beyond
    push_word(FormId, 1'b0);
    push_word(32'd0, 1'b0);
    push_word(FormAiff, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    // Restart with the largest form size, odd ID3 chunk with pad, empty chunk
    push_word(FormId, 1'b1);
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(FormAiff, 1'b0);
    push_chunk(TagId3, 32'd1, 1);
    push_chunk(TagCopy, 32'd0, 0);
    wait_drained();

    // Long receiver hold while the sender keeps offering: the unit fills up
    // and stalls its input; then the sender pauses until all results are back
    stall_left = HoldCycles;
    queued = 0;
    while (queued < 40) queued += push_random_file();
    wait_drained();

    // Random files under three idle patterns
    for (int ph = 0; ph < 3; ph++) begin
      send_gap_pct = (ph == 0) ? 30 : (ph == 1) ? 47 : 0;
      recv_gap_pct = (ph == 0) ? 47 : (ph == 1) ? 30 : 0;
      queued = 0;
      while (queued < ByteTarget / 3) queued += push_random_file();
      wait_drained();
    end

    repeat (SettleCycles) @(posedge clk);
    if (!failed) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* aiff_chunk_walker_unit.f */
design/acw_pkg.sv
design/acw_in_if.sv
design/acw_out_if.sv
design/acw_in_stage.sv
design/acw_walker.sv
design/aiff_chunk_walker_unit.sv
tb/sv/aiff_chunk_walker_unit_tb.sv
